/* src/gia_pkg.sv */
// Shared types, sizes and codes for the generational ID allocator.
// Used by the interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package gia_pkg;

    // Table sizes.
    localparam int MAX_ENTITIES   = 256;
    localparam int NUM_COMPONENTS = 32;

    // Field widths.
    localparam int ID_W   = $clog2(MAX_ENTITIES);
    localparam int CNT_W  = ID_W + 1;
    localparam int VER_W  = 32;
    localparam int KIND_W = 3;
    localparam int COMP_W = 5;
    localparam int ST_W   = 2;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DESTROY = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TEST    = 3'd5;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_UNALLOC = 2'd2;

    // One entity row: version and component mask.
    typedef struct packed {
        logic [VER_W-1:0]          ver;
        logic [NUM_COMPONENTS-1:0] mask;
    } row_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;   // capture the request and start the memory reads
        logic fetch_row;  // read the row of the ID popped from the free stack
        logic commit;     // update state and load the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stack_nonempty;
        logic out_stall;
    } dp_stat_t;

endpackage

`default_nettype wire

/* src/gia_req_if.sv */
// Request channel interface for the generational ID allocator.
// Depends on gia_pkg for the field widths.
`default_nettype none

interface gia_req_if
    import gia_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   entity_id;
    logic [VER_W-1:0]  handle_version;
    logic [COMP_W-1:0] comp_index;

    modport source (output valid, output kind, output entity_id,
                    output handle_version, output comp_index, input ready);
    modport sink   (input valid, input kind, input entity_id,
                    input handle_version, input comp_index, output ready);
endinterface

`default_nettype wire

/* src/gia_rsp_if.sv */
// Result channel interface for the generational ID allocator.
// Depends on gia_pkg for the field widths.
`default_nettype none

interface gia_rsp_if
    import gia_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  out_id;
    logic [VER_W-1:0] out_version;
    logic             answer;
    logic [ST_W-1:0]  status;

    modport source (output valid, output out_id, output out_version,
                    output answer, output status, input ready);
    modport sink   (input valid, input out_id, input out_version,
                    input answer, input status, output ready);
endinterface

`default_nettype wire

/* src/gia_ctrl.sv */
// Controller state machine of the generational ID allocator.
// Sequences request capture, the optional free-stack pop and the commit.
// Depends on gia_pkg.
`default_nettype none

module gia_ctrl
    import gia_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [KIND_W-1:0] in_kind,
    output logic                   in_ready,
    input  wire dp_stat_t          stat,
    output dp_cmd_t                cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd.load_req  = 1'b0;
        cmd.fetch_row = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_req = 1'b1;
                    if ((in_kind == KIND_CREATE) && stat.stack_nonempty)
                        state_next = S_POP;
                    else
                        state_next = S_EXEC;
                end
            end
            S_POP:
            begin
                cmd.fetch_row = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                if (!stat.out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* src/gia_dp.sv */
// Datapath of the generational ID allocator: entity row memory, free
// stack memory, counters, request register and output register.
// Depends on gia_pkg.
`default_nettype none

module gia_dp
    import gia_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic [ID_W-1:0]   entity_id,
    input  wire logic [VER_W-1:0]  handle_version,
    input  wire logic [COMP_W-1:0] comp_index,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [ID_W-1:0]        out_id,
    output logic [VER_W-1:0]       out_version,
    output logic                   answer,
    output logic [ST_W-1:0]        status
);

    // Memories. A row is written with zero when its ID is first handed out,
    // so no unwritten row's contents reach a result.
    row_t            row_mem [MAX_ENTITIES];
    logic [ID_W-1:0] stack_mem [MAX_ENTITIES];

    row_t              row_rdata_reg;
    logic [ID_W-1:0]   stack_rdata_reg;

    // Captured request.
    logic [KIND_W-1:0] req_kind_reg;
    logic [ID_W-1:0]   req_id_reg;
    logic [VER_W-1:0]  req_hver_reg;
    logic [COMP_W-1:0] req_comp_reg;

    // Counters.
    logic [CNT_W-1:0]  free_count_reg;
    logic [CNT_W-1:0]  used_count_reg;

    // Output register.
    logic              out_valid_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [VER_W-1:0]  out_version_reg;
    logic              answer_reg;
    logic [ST_W-1:0]   status_reg;

    // Commit results.
    logic [ID_W-1:0]   res_id;
    logic [VER_W-1:0]  res_ver;
    logic              res_ans;
    logic [ST_W-1:0]   res_st;
    logic              row_we;
    logic [ID_W-1:0]   row_waddr;
    row_t              row_wdata;
    logic              do_push;
    logic              do_pop;
    logic              bump_used;

    logic [ID_W-1:0]           row_raddr;
    logic                      row_re;
    logic                      comp_ok;
    logic [NUM_COMPONENTS-1:0] bit_vec;
    logic                      unalloc;

    assign stat.stack_nonempty = (free_count_reg != '0);
    assign stat.out_stall      = out_valid_reg && !out_ready;

    // Row read address: the request ID at capture, the popped ID after.
    assign row_re    = cmd.load_req || cmd.fetch_row;
    assign row_raddr = cmd.load_req ? entity_id : stack_rdata_reg;

    // Row memory port.
    always_ff @(posedge clk)
    begin
        if (row_re)
            row_rdata_reg <= row_mem[row_raddr];
        if (cmd.commit && row_we)
            row_mem[row_waddr] <= row_wdata;
    end

    // Free stack memory port: top entry read at capture, push at commit.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
            stack_rdata_reg <= stack_mem[ID_W'(free_count_reg - CNT_W'(1))];
        if (cmd.commit && do_push)
            stack_mem[free_count_reg[ID_W-1:0]] <= req_id_reg;
    end

    // Request register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_kind_reg <= kind;
            req_id_reg   <= entity_id;
            req_hver_reg <= handle_version;
            req_comp_reg <= comp_index;
        end
    end

    assign comp_ok = (int'(req_comp_reg) < NUM_COMPONENTS);
    assign bit_vec = comp_ok ? (NUM_COMPONENTS'(1) << req_comp_reg) : '0;
    assign unalloc = (CNT_W'(req_id_reg) >= used_count_reg);

    // Request evaluation on the fetched row.
    always_comb
    begin
        res_id    = req_id_reg;
        res_ver   = '0;
        res_ans   = 1'b0;
        res_st    = ST_OK;
        row_we    = 1'b0;
        row_waddr = req_id_reg;
        row_wdata = row_rdata_reg;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        bump_used = 1'b0;
        unique case (req_kind_reg) inside
            KIND_CREATE:
            begin
                if (stat.stack_nonempty)
                begin
                    res_id  = stack_rdata_reg;
                    res_ver = row_rdata_reg.ver;
                    do_pop  = 1'b1;
                end
                else if (used_count_reg < CNT_W'(MAX_ENTITIES))
                begin
                    // A fresh ID starts at version zero with an empty mask.
                    res_id    = used_count_reg[ID_W-1:0];
                    row_waddr = used_count_reg[ID_W-1:0];
                    row_wdata = '0;
                    row_we    = 1'b1;
                    bump_used = 1'b1;
                end
                else
                begin
                    res_id = '0;
                    res_st = ST_FULL;
                end
            end
            KIND_DESTROY, KIND_CHECK, KIND_SET, KIND_CLEAR, KIND_TEST:
            begin
                if (unalloc)
                begin
                    res_st = ST_UNALLOC;
                end
                else
                begin
                    res_ver = row_rdata_reg.ver;
                    case (req_kind_reg)
                        KIND_DESTROY:
                        begin
                            row_wdata.ver  = row_rdata_reg.ver + VER_W'(1);
                            row_wdata.mask = '0;
                            row_we         = 1'b1;
                            res_ver        = row_wdata.ver;
                            do_push        = (free_count_reg < CNT_W'(MAX_ENTITIES));
                        end
                        KIND_CHECK:
                        begin
                            res_ans = (row_rdata_reg.ver != req_hver_reg);
                        end
                        KIND_SET:
                        begin
                            row_wdata.mask = row_rdata_reg.mask | bit_vec;
                            row_we         = 1'b1;
                        end
                        KIND_CLEAR:
                        begin
                            row_wdata.mask = row_rdata_reg.mask & ~bit_vec;
                            row_we         = 1'b1;
                        end
                        default:
                        begin
                            res_ans = |(row_rdata_reg.mask & bit_vec);
                        end
                    endcase
                end
            end
            default:
            begin
                // Unused kinds echo the ID and change nothing.
            end
        endcase
    end

    // Counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg <= '0;
            used_count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (do_push)
                free_count_reg <= free_count_reg + CNT_W'(1);
            else if (do_pop)
                free_count_reg <= free_count_reg - CNT_W'(1);
            if (bump_used)
                used_count_reg <= used_count_reg + CNT_W'(1);
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_id_reg      <= res_id;
            out_version_reg <= res_ver;
            answer_reg      <= res_ans;
            status_reg      <= res_st;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_id      = out_id_reg;
    assign out_version = out_version_reg;
    assign answer      = answer_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

/* src/generational_id_allocator_top.sv */
// The result register loads at the commit; a create that reuses an ID from the
// free stack first passes through the pop state for an extra row read.
// The block takes no new request until the commit of the last one; a
// stalled result holds the controller in its commit state until taken.
// Reset clears the counters, the state machine and the output flag; there is
// no clearing pass, since every fresh ID zeroes its row when handed out.
// Top level of the generational ID allocator; depends on gia_pkg, the two
// channel interfaces, gia_ctrl and gia_dp.
`default_nettype none

module generational_id_allocator_top
    import gia_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    gia_req_if.sink     req,
    gia_rsp_if.source   rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    assign req.ready = in_ready;

    // Controller.
    gia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_kind  (req.kind),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath.
    gia_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .kind           (req.kind),
        .entity_id      (req.entity_id),
        .handle_version (req.handle_version),
        .comp_index     (req.comp_index),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_id         (rsp.out_id),
        .out_version    (rsp.out_version),
        .answer         (rsp.answer),
        .status         (rsp.status)
    );

endmodule

`default_nettype wire

/* src/gia_checker.sv */
// Port-level checker for the generational ID allocator, bound to the top.
// Depends on gia_pkg for widths and status codes.
`default_nettype none

module gia_checker
    import gia_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_ready,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire logic [ID_W-1:0]  out_id,
    input  wire logic [VER_W-1:0] out_version,
    input  wire logic             answer,
    input  wire logic [ST_W-1:0]  status
);

    // Only the three defined status codes appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_FULL ||
                       status == ST_UNALLOC))
        else $error("undefined status code");

    // A full-table result carries zero ID, version and answer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |->
            (out_id == '0 && out_version == '0 && !answer))
        else $error("full result carries data");

    // A never-allocated result carries zero version and answer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_UNALLOC) |-> (out_version == '0 && !answer))
        else $error("unallocated result carries data");

    // One request at a time: ready drops right after a request transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while another is in work");

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before transaction");

endmodule

bind generational_id_allocator_top gia_checker u_gia_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_id      (rsp.out_id),
    .out_version (rsp.out_version),
    .answer      (rsp.answer),
    .status      (rsp.status)
);

`default_nettype wire
